FILE: hdl/caldc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared types, action codes, calendar constants and month-length helpers.
// ----------------------------------------------------------------------------
package caldc_pkg;

	// Command codes carried in the action field.
	localparam logic [2:0] ACT_SET  = 3'd0;
	localparam logic [2:0] ACT_NEXT = 3'd1;
	localparam logic [2:0] ACT_PREV = 3'd2;
	localparam logic [2:0] ACT_ADD  = 3'd3;
	localparam logic [2:0] ACT_SUB  = 3'd4;

	// Calendar limits.
	localparam logic [15:0] YEAR_MIN   = 16'd1900;
	localparam logic [15:0] YEAR_MAX   = 16'hFFFF;
	localparam logic [15:0] YEAR_CYCLE = 16'd400;
	localparam logic [8:0]  CYC_LAST   = 9'd399;
	localparam logic [8:0]  CYC_RESET  = 9'd300;
	localparam logic [4:0]  DAY_LAST   = 5'd31;
	localparam logic [3:0]  MON_JAN    = 4'd1;
	localparam logic [3:0]  MON_FEB    = 4'd2;
	localparam logic [3:0]  MON_DEC    = 4'd12;

	// A date plus the year's position within the 400-year Gregorian cycle.
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [8:0]  ycyc;
	} date_t;

	// Leap year from the year's position in the 400-year cycle.
	function automatic logic is_leap(input logic [8:0] ycyc);
		return (ycyc[1:0] == 2'b00) && (ycyc != 9'd100) && (ycyc != 9'd200)
			&& (ycyc != 9'd300);
	endfunction

	// Number of days in a month; months outside 1..12 read as 31.
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: hdl/caldc_cmd_if.sv
// ----------------------------------------------------------------------------
// Calendar date counter command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface caldc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [4:0]  new_day;
	logic [3:0]  new_month;
	logic [15:0] new_year;
	logic [15:0] day_count;

	modport source(output valid, action, new_day, new_month, new_year, day_count,
		input ready);
	modport sink(input valid, action, new_day, new_month, new_year, day_count,
		output ready);
endinterface

FILE: hdl/caldc_res_if.sv
// ----------------------------------------------------------------------------
// Calendar date counter result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface caldc_res_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [15:0] out_year;
	logic        ok;

	modport source(output valid, out_day, out_month, out_year, ok, input ready);
	modport sink(input valid, out_day, out_month, out_year, ok, output ready);
endinterface

FILE: hdl/caldc_step.sv
// ----------------------------------------------------------------------------
// Calendar date counter day stepper
// Moves a date one day forward or back and flags the calendar limit.
// ----------------------------------------------------------------------------
module caldc_step (
	input  caldc_pkg::date_t cur,
	input  logic             back,
	output caldc_pkg::date_t nxt,
	output logic             at_limit
);

	logic [4:0] len_cur;
	logic [4:0] len_prev;
	logic [3:0] mon_prev;
	logic       leap_cur;

	// Month lengths needed for both directions.
	assign leap_cur = caldc_pkg::is_leap(cur.ycyc);
	assign mon_prev = cur.month - 4'd1;
	assign len_cur  = caldc_pkg::month_len(cur.month, leap_cur);
	assign len_prev = caldc_pkg::month_len(mon_prev, leap_cur);

	// Limit detection: ceiling going forward, floor going back.
	always_comb begin
		if (back) begin
			at_limit = (cur.year <= caldc_pkg::YEAR_MIN) && (cur.month == caldc_pkg::MON_JAN)
				&& (cur.day <= 5'd1);
		end else begin
			at_limit = (cur.year == caldc_pkg::YEAR_MAX) && (cur.month == caldc_pkg::MON_DEC)
				&& (cur.day >= caldc_pkg::DAY_LAST);
		end
	end

	// One day of movement with month and year roll.
	always_comb begin
		nxt = cur;
		if (back) begin
			if (cur.day > 5'd1) begin
				nxt.day = cur.day - 5'd1;
			end else if (cur.month > caldc_pkg::MON_JAN) begin
				nxt.month = mon_prev;
				nxt.day   = len_prev;
			end else begin
				nxt.month = caldc_pkg::MON_DEC;
				nxt.day   = caldc_pkg::DAY_LAST;
				nxt.year  = cur.year - 16'd1;
				nxt.ycyc  = (cur.ycyc == 9'd0) ? caldc_pkg::CYC_LAST : cur.ycyc - 9'd1;
			end
		end else begin
			if (cur.day < len_cur) begin
				nxt.day = cur.day + 5'd1;
			end else if (cur.month < caldc_pkg::MON_DEC) begin
				nxt.day   = 5'd1;
				nxt.month = cur.month + 4'd1;
			end else begin
				nxt.day   = 5'd1;
				nxt.month = caldc_pkg::MON_JAN;
				nxt.year  = cur.year + 16'd1;
				nxt.ycyc  = (cur.ycyc == caldc_pkg::CYC_LAST) ? 9'd0 : cur.ycyc + 9'd1;
			end
		end
	end

endmodule

FILE: hdl/calendar_date_counter_unit.sv
// ----------------------------------------------------------------------------
// Calendar date counter unit
// Holds a Gregorian date from 1900-01-01 and executes one command per beat.
// ----------------------------------------------------------------------------
// The unit takes one command at a time; cmd.ready is high only while it is
// idle. A set command first reduces the year modulo 400 for the leap rule,
// then validates the date and then loads the result register. Next-day,
// previous-day and a preview add or subtract of n days (which stops early if
// it hits the calendar limit first) all run the working date through one
// shared day stepper, which advances it by one day per cycle. A finished
// result waits in the output register, and the unit takes the next command
// once it has loaded its result into that register.
module calendar_date_counter_unit #(
	parameter int COUNT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	caldc_cmd_if.sink  cmd,
	caldc_res_if.source res
);

	localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]        state_q;
	caldc_pkg::date_t  cur_q;
	caldc_pkg::date_t  wrk_q;
	logic              ok_q;
	logic              commit_q;
	logic              back_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       rem_q;
	logic [2:0]        k_q;
	logic              res_valid_q;
	caldc_pkg::date_t  res_q;
	logic              res_ok_q;

	caldc_pkg::date_t  step_nxt;
	logic              step_lim;
	logic [15:0]       sub_val;
	logic              set_valid;
	logic              out_free;
	logic              accept;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;
	assign sub_val  = caldc_pkg::YEAR_CYCLE << k_q;

	// Shared day stepper, used by next, previous and both previews.
	caldc_step u_step (
		.cur      (wrk_q),
		.back     (back_q),
		.nxt      (step_nxt),
		.at_limit (step_lim)
	);

	// Date check for a set, once the year has been reduced modulo 400.
	always_comb begin
		set_valid = (wrk_q.year >= caldc_pkg::YEAR_MIN) && (wrk_q.month >= caldc_pkg::MON_JAN)
			&& (wrk_q.month <= caldc_pkg::MON_DEC) && (wrk_q.day >= 5'd1)
			&& (wrk_q.day <= caldc_pkg::month_len(wrk_q.month,
				caldc_pkg::is_leap(rem_q[8:0])));
	end

	// Sequencer state and the stored date.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '{day: 5'd1, month: caldc_pkg::MON_JAN, year: caldc_pkg::YEAR_MIN,
				ycyc: caldc_pkg::CYC_RESET};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							caldc_pkg::ACT_SET:  state_q <= ST_MOD;
							caldc_pkg::ACT_NEXT,
							caldc_pkg::ACT_PREV,
							caldc_pkg::ACT_ADD,
							caldc_pkg::ACT_SUB:  state_q <= ST_RUN;
							default:             state_q <= ST_FIN;
						endcase
					end
				end
				ST_MOD: begin
					if (k_q == 3'd0) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= ST_FIN;
				end
				ST_RUN: begin
					if (cnt_q == '0 || step_lim) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (commit_q) begin
							cur_q <= wrk_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working date, day counter and year reduction.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					back_q <= (cmd.action == caldc_pkg::ACT_PREV)
						|| (cmd.action == caldc_pkg::ACT_SUB);
					rem_q  <= cmd.new_year;
					k_q    <= 3'd7;
					case (cmd.action)
						caldc_pkg::ACT_SET: begin
							wrk_q    <= '{day: cmd.new_day, month: cmd.new_month,
								year: cmd.new_year, ycyc: cur_q.ycyc};
							ok_q     <= 1'b1;
							commit_q <= 1'b0;
							cnt_q    <= cmd.day_count[CNT_W-1:0];
						end
						caldc_pkg::ACT_NEXT,
						caldc_pkg::ACT_PREV: begin
							wrk_q    <= cur_q;
							ok_q     <= 1'b1;
							commit_q <= 1'b1;
							cnt_q    <= CNT_W'(1);
						end
						caldc_pkg::ACT_ADD,
						caldc_pkg::ACT_SUB: begin
							wrk_q    <= cur_q;
							ok_q     <= 1'b1;
							commit_q <= 1'b0;
							cnt_q    <= cmd.day_count[CNT_W-1:0];
						end
						default: begin
							wrk_q    <= cur_q;
							ok_q     <= 1'b0;
							commit_q <= 1'b0;
							cnt_q    <= cmd.day_count[CNT_W-1:0];
						end
					endcase
				end
			end
			ST_MOD: begin
				// Restoring reduction by 400 * 2^k, one step per cycle.
				if (rem_q >= sub_val) begin
					rem_q <= rem_q - sub_val;
				end
				k_q <= k_q - 3'd1;
			end
			ST_CHK: begin
				if (set_valid) begin
					wrk_q.ycyc <= rem_q[8:0];
					commit_q   <= 1'b1;
				end else begin
					wrk_q <= cur_q;
					ok_q  <= 1'b0;
				end
			end
			ST_RUN: begin
				if (cnt_q != '0) begin
					if (step_lim) begin
						if (!back_q) begin
							ok_q <= 1'b0;
						end
					end else begin
						wrk_q <= step_nxt;
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			res_q    <= wrk_q;
			res_ok_q <= ok_q;
		end
	end

	assign cmd.ready     = (state_q == ST_IDLE);
	assign res.valid     = res_valid_q;
	assign res.out_day   = res_q.day;
	assign res.out_month = res_q.month;
	assign res.out_year  = res_q.year;
	assign res.ok        = res_ok_q;

	// The stored date is always a valid calendar date.
	a_cur_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.month >= caldc_pkg::MON_JAN) && (cur_q.month <= caldc_pkg::MON_DEC)
		&& (cur_q.day >= 5'd1) && (cur_q.year >= caldc_pkg::YEAR_MIN)
		&& (cur_q.day <= caldc_pkg::month_len(cur_q.month, caldc_pkg::is_leap(cur_q.ycyc))))
		else $error("stored date is not a valid calendar date");

	// A result beat only appears after the finish step.
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish step");

	// Previews never disturb the stored date.
	a_preview_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !commit_q) |=> $stable(cur_q))
		else $error("stored date changed during a preview");

	// The working date never walks below the floor year.
	a_run_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (wrk_q.year >= caldc_pkg::YEAR_MIN))
		else $error("working date went below the floor year");

endmodule
